// ===== rtl/olirs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list package
// Shared sizes, operation and status codes, and word types for the ordered
// list core and its cells.
// ----------------------------------------------------------------------------
package olirs_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND  = 3'd0,
        FUNC_INSERT  = 3'd1,
        FUNC_REM_TL  = 3'd2,
        FUNC_REM_VAL = 3'd3,
        FUNC_SWAP    = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SWAP
    } t_cell_op;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic signed [VAL_W-1:0] item_value;
        logic [POS_W-1:0]        position_a;
        logic [POS_W-1:0]        position_b;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] removed_value;
        logic [CNT_W-1:0]        entry_total;
    } t_out_word;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        t_cell_op                op;
        logic [VAL_W-1:0]        value;
        logic [CNT_W-1:0]        pos_a;
        logic [CNT_W-1:0]        pos_b;
        logic [CNT_W-1:0]        count;
        logic [VAL_W-1:0]        lo_value;
        logic [VAL_W-1:0]        hi_value;
    } t_cell_ctl;

endpackage

// ===== rtl/ordered_list_insert_remove_swap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list core
// Bounded ordered list of signed 32-bit values with append, insert, remove
// tail, remove by value and swap, held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage: each input word carries one operation (func, item_value,
// position_a, position_b) and produces exactly one output word (status,
// removed_value, entry_total). Both channels use valid and stall; a word
// moves on a rising edge where valid is high and stall is low.
// The result of a word is registered at the edge that accepts it and
// shown on the output from then on. Throughput is one word per cycle
// while the output is not stalled, since every cell compares, shifts or
// loads in parallel in the cycle of acceptance; the cycle time is set by
// the match chain from the head cell to the tail cell for remove by value.
// The result sits in an output register. While it is stalled the input
// channel is stalled too; when the receiver takes it, a new word may be
// accepted in the same cycle.
// Reset clears the entry count and the output valid. Cell contents are not
// reset: only cells below the count are ever read, and each of those has
// been written since reset.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_swap_core
    import olirs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    // Entry count and the registered result word.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_word        r_out_word;
    t_out_word        n_out_word;

    logic             w_accept;
    t_cell_ctl        w_ctl;

    // Per-cell connections of the row.
    logic [VAL_W-1:0] w_value [CAPACITY];
    logic             w_match [CAPACITY];
    logic             w_hit   [CAPACITY + 1];

    // Values read out of the row by one-hot selection.
    logic [VAL_W-1:0] w_tail_value;
    logic [VAL_W-1:0] w_lo_value;
    logic [VAL_W-1:0] w_hi_value;
    logic             w_tail_hit;
    logic [CNT_W-1:0] w_tail_idx;
    logic [POS_W-1:0] w_lo;
    logic [POS_W-1:0] w_hi;
    logic             w_full;
    logic             w_empty;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_full      = (r_count >= CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_tail_idx  = r_count - CNT_W'(1);
    assign w_lo = (i_in_word.position_a < i_in_word.position_b) ?
                  i_in_word.position_a : i_in_word.position_b;
    assign w_hi = (i_in_word.position_a < i_in_word.position_b) ?
                  i_in_word.position_b : i_in_word.position_a;

    // AND-OR read of the tail and the two swap positions, and the tail
    // comparison that gives remove by value its priority on the tail.
    always_comb begin
        w_tail_value = '0;
        w_lo_value   = '0;
        w_hi_value   = '0;
        w_tail_hit   = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!w_empty && (CNT_W'(i) == w_tail_idx)) begin
                w_tail_value = w_tail_value | w_value[i];
                w_tail_hit   = w_tail_hit | w_match[i];
            end
            if (32'(i) == 32'(w_lo)) begin
                w_lo_value = w_lo_value | w_value[i];
            end
            if (32'(i) == 32'(w_hi)) begin
                w_hi_value = w_hi_value | w_value[i];
            end
        end
    end

    // Decode of the operation into the cell command, the new count and the
    // result word.
    always_comb begin
        w_ctl.op       = CELL_HOLD;
        w_ctl.value    = i_in_word.item_value;
        w_ctl.pos_a    = CNT_W'(i_in_word.position_a);
        w_ctl.pos_b    = '0;
        w_ctl.count    = r_count;
        w_ctl.lo_value = w_lo_value;
        w_ctl.hi_value = w_hi_value;
        n_count                  = r_count;
        n_out_word.status        = ST_OK;
        n_out_word.removed_value = '1;
        case (i_in_word.func)
            FUNC_APPEND: begin
                if (w_full) begin
                    n_out_word.status = ST_FULL;
                end else begin
                    w_ctl.op    = CELL_INSERT;
                    w_ctl.pos_a = r_count;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            FUNC_INSERT: begin
                if (32'(i_in_word.position_a) > 32'(r_count)) begin
                    n_out_word.status = ST_BADPOS;
                end else if (w_full) begin
                    n_out_word.status = ST_FULL;
                end else begin
                    w_ctl.op = CELL_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            FUNC_REM_TL: begin
                if (w_empty) begin
                    n_out_word.status = ST_EMPTY;
                end else begin
                    n_out_word.removed_value = w_tail_value;
                    n_count                  = w_tail_idx;
                end
            end
            FUNC_REM_VAL: begin
                if (w_empty) begin
                    n_out_word.status = ST_EMPTY;
                end else begin
                    // Cells close the gap themselves; a tail hit only drops
                    // the count.
                    w_ctl.op = CELL_REMOVE;
                    if (w_hit[CAPACITY]) begin
                        n_out_word.removed_value = i_in_word.item_value;
                        n_count                  = w_tail_idx;
                    end else begin
                        n_out_word.status = ST_NOTFOUND;
                    end
                end
            end
            FUNC_SWAP: begin
                if ((w_lo == w_hi) || (32'(w_hi) >= 32'(r_count))) begin
                    n_out_word.status = ST_BADPOS;
                end else begin
                    w_ctl.op    = CELL_SWAP;
                    w_ctl.pos_a = CNT_W'(w_lo);
                    w_ctl.pos_b = CNT_W'(w_hi);
                end
            end
            default: begin
                n_out_word.status = ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_ctl.op = CELL_HOLD;
        end
        n_out_word.entry_total = n_count;
    end

    assign w_hit[0] = 1'b0;

    // The row of cells, head at index zero.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = i_in_word.item_value;
        end else begin : g_body
            assign w_left = w_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_value[g];
        end else begin : g_inner
            assign w_right = w_value[g+1];
        end

        olirs_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_ctl        (w_ctl),
            .i_tail_hit   (w_tail_hit),
            .i_hit        (w_hit[g]),
            .i_left_value (w_left),
            .i_right_value(w_right),
            .o_hit        (w_hit[g+1]),
            .o_match      (w_match[g]),
            .o_value      (w_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

// ===== rtl/olirs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry, compares it against the search value and takes its
// next value from the command, its left or its right neighbour.
// ----------------------------------------------------------------------------
module olirs_cell
    import olirs_pkg::*;
(
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctl        i_ctl,
    input  logic             i_tail_hit,
    input  logic             i_hit,
    input  logic [VAL_W-1:0] i_left_value,
    input  logic [VAL_W-1:0] i_right_value,
    output logic             o_hit,
    output logic             o_match,
    output logic [VAL_W-1:0] o_value
);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    logic [CNT_W-1:0] w_idx;

    assign w_idx   = CNT_W'(i_index);
    assign o_value = r_value;
    assign o_match = (w_idx < i_ctl.count) && (r_value == i_ctl.value);
    // A match here or anywhere nearer the head moves this cell forward.
    assign o_hit   = i_hit | o_match;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (w_idx == i_ctl.pos_a) begin
                    n_value = i_ctl.value;
                end else if ((w_idx > i_ctl.pos_a) && (w_idx <= i_ctl.count)) begin
                    n_value = i_left_value;
                end
            end
            CELL_REMOVE: begin
                if (o_hit && !i_tail_hit) begin
                    n_value = i_right_value;
                end
            end
            CELL_SWAP: begin
                if (w_idx == i_ctl.pos_a) begin
                    n_value = i_ctl.hi_value;
                end else if (w_idx == i_ctl.pos_b) begin
                    n_value = i_ctl.lo_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== rtl/olirs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list port checker
// Checks the result words seen on the ports of the ordered list core.
// ----------------------------------------------------------------------------
module olirs_checker
    import olirs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_word o_out_word,
    input logic      i_out_stall
);

    // A stalled result word stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_word.entry_total) <= CAPACITY))
        else $error("entry total beyond capacity");

    // Any failure leaves nothing removed.
    a_fail_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ST_OK) |->
            (o_out_word.removed_value == -32'sd1))
        else $error("failed operation reports a removed value");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_EMPTY) |->
            (o_out_word.entry_total == '0))
        else $error("empty status with entries present");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_FULL) |->
            (32'(o_out_word.entry_total) == CAPACITY))
        else $error("full status without a full list");

endmodule

bind ordered_list_insert_remove_swap_core olirs_checker u_olirs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .o_out_word (o_out_word),
    .i_out_stall(i_out_stall)
);
